/* design/sglm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sglm_pkg
// Types, constants and helpers shared by the sequence gap loss monitor.
// ----------------------------------------------------------------------------
package sglm_pkg;

	localparam int unsigned WORD_W        = 32;
	localparam int unsigned IN_TDATA_W    = 64;
	localparam int unsigned OUT_TDATA_W   = 296;
	localparam int unsigned QUEUE_DEPTH   = 4;
	localparam int unsigned QUEUE_AW      = 2;
	localparam logic [31:0] STALL_THR_RST = 32'd65217;
	localparam logic [31:0] ALL_ONES      = 32'hffff_ffff;

	// classified beat handed from the front to the back
	typedef struct packed {
		logic signed [31:0] gap;
		logic               ev;
		logic [31:0]        mag;
		logic [31:0]        ivl;
		logic               stall;
	} item_t;

	// result beat, last field in the lowest bits
	typedef struct packed {
		logic [4:0]         pad;
		logic               stall_flag;
		logic [31:0]        interval;
		logic [31:0]        largest_gap;
		logic [31:0]        smallest_gap;
		logic [31:0]        gap_events;
		logic [31:0]        total_lost;
		logic [31:0]        cluster_total;
		logic               cluster_closed;
		logic [31:0]        bin_count;
		logic [31:0]        gap_magnitude;
		logic               gap_event;
		logic signed [31:0] gap_signed;
	} result_t;

	// saturating unsigned add
	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? ALL_ONES : s[31:0];
	endfunction

endpackage
`default_nettype wire

/* design/sglm_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sglm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sglm_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, returns the contents before a same-edge write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

/* design/sglm_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sglm_fifo
// Short queue of classified beats between the front and the back.
// ----------------------------------------------------------------------------
module sglm_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire sglm_pkg::item_t push_data,
	output logic                full,
	input  wire logic           pop,
	output logic                head_vld,
	output sglm_pkg::item_t     head_data
);
	import sglm_pkg::*;

	item_t               ent_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   cnt_q;
	logic                do_push;
	logic                do_pop;

	assign full      = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign head_vld  = (cnt_q != '0);
	assign head_data = ent_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && head_vld;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* design/sglm_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sglm_front
// Accepts packet beats, tracks the previous sequence and tick, and
// classifies each beat: signed gap, magnitude, interval and stall.
// ----------------------------------------------------------------------------
module sglm_front (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic        in_vld,
	output logic             in_rdy,
	input  wire logic [31:0] seq,
	input  wire logic [31:0] tick,
	output logic             push,
	output sglm_pkg::item_t  push_data,
	input  wire logic        q_full
);
	import sglm_pkg::*;

	logic        seen_q;
	logic [31:0] prev_seq_q;
	logic [31:0] prev_tick_q;
	logic [31:0] thr_q;
	logic        vld_s1;
	logic [31:0] gap_s1;
	logic [31:0] ivl_s1;
	logic        acc;

	assign in_rdy = !vld_s1 || !q_full;
	assign acc    = in_vld && in_rdy;
	assign push   = vld_s1 && !q_full;

	// stall threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= STALL_THR_RST;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// previous packet state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= 1'b0;
			prev_seq_q  <= '0;
			prev_tick_q <= '0;
		end else if (acc) begin
			seen_q      <= 1'b1;
			prev_seq_q  <= seq;
			prev_tick_q <= tick;
		end
	end

	// stage 1: gap and interval, zero for the first packet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (acc) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			gap_s1 <= seen_q ? (seq + ~prev_seq_q) : '0;
			ivl_s1 <= seen_q ? (tick - prev_tick_q) : '0;
		end
	end

	// stage 2: magnitude, event and stall flags into the queue
	always_comb begin
		push_data.gap   = signed'(gap_s1);
		push_data.ev    = (gap_s1 != '0);
		push_data.mag   = gap_s1[31] ? (~gap_s1 + 32'd1) : gap_s1;
		push_data.ivl   = ivl_s1;
		push_data.stall = (ivl_s1 > thr_q);
	end

endmodule
`default_nettype wire

/* design/sglm_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sglm_back
// Applies classified beats to the loss statistics, the cluster sum and the
// gap histogram, and holds the result beat in an output register.
// ----------------------------------------------------------------------------
module sglm_back #(
	parameter int unsigned NUM_BINS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          head_vld,
	input  wire sglm_pkg::item_t               head_data,
	output logic                               pop,
	output logic                               out_vld,
	input  wire logic                          out_rdy,
	output logic [sglm_pkg::OUT_TDATA_W-1:0]   out_data
);
	import sglm_pkg::*;

	localparam int unsigned BIN_AW = $clog2(NUM_BINS);

	logic [BIN_AW-1:0]   head_idx;
	logic                vld_s1;
	item_t               item_s1;
	logic [BIN_AW-1:0]   idx_s1;
	logic                bvld_s1;
	logic [NUM_BINS-1:0] bin_vld_q;
	logic                lw_vld_q;
	logic [BIN_AW-1:0]   lw_idx_q;
	logic [31:0]         lw_val_q;
	logic [31:0]         ram_rdata;
	logic [31:0]         bin_cur;
	logic [31:0]         bin_new;
	logic                adv;
	logic                bin_we;
	logic                closing;
	logic [31:0]         lost_q;
	logic [31:0]         events_q;
	logic [31:0]         min_q;
	logic [31:0]         max_q;
	logic [31:0]         streak_q;
	logic [31:0]         lost_n;
	logic [31:0]         events_n;
	logic [31:0]         min_n;
	logic [31:0]         max_n;
	logic                out_vld_q;
	result_t             res;
	result_t             res_q;

	// bin index at the queue head, top bin holds the overflow
	assign head_idx = (head_data.mag >= 32'(NUM_BINS - 1)) ? BIN_AW'(NUM_BINS - 1)
	                                                       : head_data.mag[BIN_AW-1:0];

	assign adv = vld_s1 && (!out_vld_q || out_rdy);
	assign pop = head_vld && (!vld_s1 || adv);

	// stage 1: histogram read issued as the beat leaves the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (pop) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_s1 <= head_data;
			idx_s1  <= head_idx;
			bvld_s1 <= bin_vld_q[head_idx];
		end
	end

	sglm_ram #(
		.WIDTH (WORD_W),
		.DEPTH (NUM_BINS)
	) u_bins (
		.clk   (clk),
		.we    (bin_we),
		.waddr (idx_s1),
		.wdata (bin_new),
		.re    (pop),
		.raddr (head_idx),
		.rdata (ram_rdata)
	);

	// current bin value: newest write wins, unwritten bins read as zero
	always_comb begin
		if (lw_vld_q && (lw_idx_q == idx_s1)) begin
			bin_cur = lw_val_q;
		end else if (bvld_s1) begin
			bin_cur = ram_rdata;
		end else begin
			bin_cur = '0;
		end
		bin_new = sat_add(bin_cur, 32'd1);
	end

	assign bin_we  = adv && item_s1.ev;
	assign closing = !item_s1.ev && (streak_q != '0);

	// bin valid bits and last-write forwarding register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_vld_q <= '0;
			lw_vld_q  <= 1'b0;
			lw_idx_q  <= '0;
			lw_val_q  <= '0;
		end else if (bin_we) begin
			bin_vld_q[idx_s1] <= 1'b1;
			lw_vld_q          <= 1'b1;
			lw_idx_q          <= idx_s1;
			lw_val_q          <= bin_new;
		end
	end

	// next running statistics
	always_comb begin
		lost_n   = lost_q;
		events_n = events_q;
		min_n    = min_q;
		max_n    = max_q;
		if (item_s1.ev) begin
			lost_n   = sat_add(lost_q, item_s1.mag);
			events_n = sat_add(events_q, 32'd1);
			if (item_s1.mag < min_q) begin
				min_n = item_s1.mag;
			end
			if (item_s1.mag > max_q) begin
				max_n = item_s1.mag;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lost_q   <= '0;
			events_q <= '0;
			min_q    <= ALL_ONES;
			max_q    <= '0;
			streak_q <= '0;
		end else if (adv) begin
			lost_q   <= lost_n;
			events_q <= events_n;
			min_q    <= min_n;
			max_q    <= max_n;
			if (item_s1.ev) begin
				streak_q <= sat_add(streak_q, item_s1.mag);
			end else if (closing) begin
				streak_q <= '0;
			end
		end
	end

	// result beat
	always_comb begin
		res.pad            = '0;
		res.stall_flag     = item_s1.stall;
		res.interval       = item_s1.ivl;
		res.largest_gap    = max_n;
		res.smallest_gap   = (min_n == ALL_ONES) ? '0 : min_n;
		res.gap_events     = events_n;
		res.total_lost     = lost_n;
		res.cluster_total  = closing ? streak_q : '0;
		res.cluster_closed = closing;
		res.bin_count      = item_s1.ev ? bin_new : '0;
		res.gap_magnitude  = item_s1.mag;
		res.gap_event      = item_s1.ev;
		res.gap_signed     = item_s1.gap;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= 1'b1;
		end else if (out_rdy) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign out_vld  = out_vld_q;
	assign out_data = res_q;

endmodule
`default_nettype wire

/* design/sequence_gap_loss_monitor.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sequence_gap_loss_monitor
// Packet loss monitor: sequence gaps, loss totals, gap histogram, loss
// clusters and arrival stalls, one result beat per packet beat.
//
// channel   direction  tdata fields (lowest bit first)
// s_axis    in         seq_number, arrival_tick
// m_axis    out        gap_signed .. stall_flag (see port list)
// cfg       in         stall threshold, written when cfg_we is high
//
// One packet beat per cycle, sustained while result beats are taken; the
// histogram read-modify-write keeps pace by forwarding the last bin written.
// A result beat passes the front stage 1 register, the queue, the back stage 1
// register and the output register before it is offered.
// A four-entry queue parts the front from the back; the front stalls only
// when the queue is full, the back only when the result register is held.
// Reset clears all statistics and histogram bins at once.
// ----------------------------------------------------------------------------
module sequence_gap_loss_monitor #(
	parameter int unsigned NUM_BINS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [31:0]                       cfg_wdata,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// seq_number[31:0], arrival_tick[63:32]
	input  wire logic [sglm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// gap_signed[31:0], gap_event[32], gap_magnitude[64:33], bin_count[96:65],
	// cluster_closed[97], cluster_total[129:98], total_lost[161:130],
	// gap_events[193:162], smallest_gap[225:194], largest_gap[257:226],
	// interval[289:258], stall_flag[290], zero fill[295:291]
	output logic [sglm_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);
	import sglm_pkg::*;

	logic  push;
	item_t push_data;
	logic  q_full;
	logic  pop;
	logic  head_vld;
	item_t head_data;

	// front: accept and classify
	sglm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_vld    (s_axis_tvalid),
		.in_rdy    (s_axis_tready),
		.seq       (s_axis_tdata[31:0]),
		.tick      (s_axis_tdata[63:32]),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	// queue between the two halves
	sglm_fifo u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.head_vld  (head_vld),
		.head_data (head_data)
	);

	// back: statistics, histogram and result register
	sglm_back #(
		.NUM_BINS (NUM_BINS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_vld  (head_vld),
		.head_data (head_data),
		.pop       (pop),
		.out_vld   (m_axis_tvalid),
		.out_rdy   (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule
`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sequence gap loss monitor. Packet beats go in
// with bursty spacing while the result side stalls on its own schedule. A
// scoreboard model tracks gaps, loss totals, the histogram, clusters and
// stalls, and each result beat is compared field by field. Directed cases
// are mixed with random phases, each phase at its own stall threshold.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sglm_pkg::*;

	localparam int unsigned NUM_BINS = 16;
	localparam int unsigned BIN_LAST = NUM_BINS - 1;

	typedef enum int unsigned {RX_ALWAYS, RX_MOSTLY, RX_PATTERN, RX_SPARSE} rx_mode_e;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [31:0]            cfg_wdata = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	sequence_gap_loss_monitor #(
		.NUM_BINS(NUM_BINS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	// loss tracking model state
	logic        trk_started = 1'b0;
	logic [31:0] trk_seq = '0;
	logic [31:0] trk_tick = '0;
	logic [31:0] trk_streak = '0;
	logic [31:0] trk_lost = '0;
	logic [31:0] trk_events = '0;
	logic [31:0] trk_min = ALL_ONES;
	logic [31:0] trk_max = '0;
	logic [31:0] trk_thr = STALL_THR_RST;
	logic [31:0] trk_bins [NUM_BINS] = '{default: '0};

	result_t     expected_reports[$];

	// run statistics
	int unsigned n_fail = 0;
	int unsigned n_packets = 0;
	int unsigned n_checked = 0;
	int unsigned n_gap_events = 0;
	int unsigned n_closes = 0;
	int unsigned n_stalls = 0;
	int unsigned n_thr_writes = 0;

	// sender and receiver control
	logic [31:0] tx_seq = '0;
	logic [31:0] tx_tick = '0;
	int unsigned tx_burst_left = 0;
	bit          tx_steady = 1'b0;
	int unsigned rx_hold_req = 0;

	// clock
	initial begin
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic [31:0] clamp_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? ALL_ONES : s[31:0];
	endfunction

	// work out the report for one packet beat and queue it
	task automatic track_packet(input logic [31:0] seq, input logic [31:0] tick);
		result_t     r;
		logic [31:0] gap;
		int unsigned bin;
		r = '0;
		if (trk_started) begin
			gap = seq - trk_seq - 32'd1;
			r.gap_signed = gap;
			r.gap_magnitude = gap[31] ? (~gap + 32'd1) : gap;
			r.interval = tick - trk_tick;
			r.stall_flag = (r.interval > trk_thr);
			if (gap != '0) begin
				if (r.gap_magnitude >= 32'(BIN_LAST))
					bin = BIN_LAST;
				else
					bin = r.gap_magnitude;
				r.gap_event = 1'b1;
				trk_lost = clamp_add(trk_lost, r.gap_magnitude);
				trk_events = clamp_add(trk_events, 32'd1);
				if (r.gap_magnitude < trk_min)
					trk_min = r.gap_magnitude;
				if (r.gap_magnitude > trk_max)
					trk_max = r.gap_magnitude;
				trk_bins[bin] = clamp_add(trk_bins[bin], 32'd1);
				r.bin_count = trk_bins[bin];
				trk_streak = clamp_add(trk_streak, r.gap_magnitude);
			end else if (trk_streak != '0) begin
				r.cluster_closed = 1'b1;
				r.cluster_total = trk_streak;
				trk_streak = '0;
			end
		end
		trk_started = 1'b1;
		trk_seq = seq;
		trk_tick = tick;
		r.total_lost = trk_lost;
		r.gap_events = trk_events;
		r.smallest_gap = (trk_min == ALL_ONES) ? '0 : trk_min;
		r.largest_gap = trk_max;
		n_packets++;
		n_gap_events += r.gap_event;
		n_closes += r.cluster_closed;
		n_stalls += r.stall_flag;
		expected_reports.insert(expected_reports.size(), r);
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%08h, got 0x%08h", name, want, got);
			n_fail++;
		end
	endtask

	// accepted packet beats feed the model
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			track_packet(s_axis_tdata[31:0], s_axis_tdata[63:32]);
	end

	// each accepted result beat against the oldest expectation
	always @(posedge clk) begin : check_report
		result_t want;
		result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (expected_reports.size() == 0) begin
				$error("result beat with nothing expected: 0x%0h", m_axis_tdata);
				n_fail++;
			end else begin
				want = expected_reports.pop_front();
				n_checked++;
				compare_field("gap_signed", want.gap_signed, got.gap_signed);
				compare_field("gap_event", 32'(want.gap_event), 32'(got.gap_event));
				compare_field("gap_magnitude", want.gap_magnitude, got.gap_magnitude);
				compare_field("bin_count", want.bin_count, got.bin_count);
				compare_field("cluster_closed", 32'(want.cluster_closed),
					32'(got.cluster_closed));
				compare_field("cluster_total", want.cluster_total, got.cluster_total);
				compare_field("total_lost", want.total_lost, got.total_lost);
				compare_field("gap_events", want.gap_events, got.gap_events);
				compare_field("smallest_gap", want.smallest_gap, got.smallest_gap);
				compare_field("largest_gap", want.largest_gap, got.largest_gap);
				compare_field("interval", want.interval, got.interval);
				compare_field("stall_flag", 32'(want.stall_flag), 32'(got.stall_flag));
				compare_field("zero_fill", 32'(want.pad), 32'(got.pad));
			end
		end
	end

	// result side ready: changing stall modes, plus long hold-offs on request
	initial begin : rx_side
		int unsigned hold_left;
		int unsigned mode_left;
		rx_mode_e    mode;
		logic [7:0]  pattern;
		hold_left = 0;
		mode_left = 0;
		mode = RX_ALWAYS;
		pattern = '1;
		forever begin
			@(negedge clk);
			if (rx_hold_req != 0) begin
				hold_left = rx_hold_req;
				rx_hold_req = 0;
			end
			if (mode_left == 0) begin
				mode = rx_mode_e'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 200);
				pattern = 8'($urandom());
			end
			mode_left--;
			pattern = {pattern[6:0], pattern[7]};
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				case (mode)
					RX_ALWAYS:  m_axis_tready <= 1'b1;
					RX_MOSTLY:  m_axis_tready <= ($urandom_range(0, 3) != 0);
					RX_PATTERN: m_axis_tready <= pattern[0];
					default:    m_axis_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// offer one packet beat, with a random gap at the start of each burst
	task automatic send_packet(input logic [31:0] seq, input logic [31:0] tick);
		int unsigned gap_cycles;
		gap_cycles = 0;
		if (!tx_steady) begin
			if (tx_burst_left == 0) begin
				tx_burst_left = $urandom_range(1, 24);
				gap_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			end
			tx_burst_left--;
		end
		@(negedge clk);
		if (gap_cycles != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap_cycles) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {tick, seq};
		tx_seq = seq;
		tx_tick = tick;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// next packet relative to the last one: signed gap and tick interval
	task automatic send_offset(input logic [31:0] gap, input logic [31:0] ivl);
		send_packet(tx_seq + 32'd1 + gap, tx_tick + ivl);
	endtask

	// stop offering and let every expected report come out
	task automatic wait_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [31:0] value);
		wait_idle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		trk_thr = value;
		n_thr_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// first packet only latches, then a wrap of both counters
	task automatic test_first_packet();
		send_packet(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_packet(32'h0000_0000, 32'h0000_0000);
		send_packet(32'h0000_0001, 32'h0000_0000);
	endtask

	// small forward, backward and duplicate gaps, histogram edges, clusters
	task automatic test_small_gaps();
		send_offset(1, 10);
		send_offset(2, 10);
		send_offset(0, 10);
		send_offset(14, 5);
		send_offset(15, 5);
		send_offset(16, 5);
		send_offset(-1, 5);
		send_offset(-8, 5);
		send_offset(0, 5);
		send_offset(0, 5);
	endtask

	// interval at and just past the threshold, and the threshold extremes
	task automatic test_stall_threshold();
		send_offset(0, STALL_THR_RST);
		send_offset(0, STALL_THR_RST + 32'd1);
		send_offset(0, ALL_ONES);
		write_threshold('0);
		send_offset(0, 0);
		send_offset(0, 1);
		write_threshold(ALL_ONES);
		send_offset(0, ALL_ONES);
		send_offset(3, 0);
	endtask

	// largest forward and most negative gap: loss total and cluster saturate
	task automatic test_gap_extremes();
		send_offset(32'h7FFF_FFFF, 1);
		send_offset(32'h8000_0000, 1);
		send_offset(32'h8000_0000, 1);
		send_offset(0, 1);
	endtask

	// hold the result side off while packets keep coming, so the input stalls
	task automatic test_backpressure();
		wait_idle();
		rx_hold_req = 80;
		tx_steady = 1'b1;
		repeat (40)
			send_offset(($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0,
				$urandom_range(0, 2000));
		tx_steady = 1'b0;
		wait_idle();
	endtask

	// mostly orderly traffic with random loss; large jumps only when wild
	task automatic test_random_traffic(input logic [31:0] thr, input int unsigned count,
			input bit wild);
		logic [31:0] seq;
		logic [31:0] ivl;
		int unsigned pick;
		write_threshold(thr);
		tx_steady = ($urandom_range(0, 3) == 0);
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 55)
				seq = tx_seq + 32'd1;
			else if (pick < 72)
				seq = tx_seq + 32'd1 + $urandom_range(1, 20);
			else if (pick < 84 || !wild)
				seq = tx_seq - $urandom_range(0, 12);
			else if (pick < 90)
				seq = tx_seq + 32'd1 + $urandom();
			else if (pick < 95)
				seq = $urandom();
			else if (pick < 98)
				seq = tx_seq + 32'd1 + 32'h8000_0000;
			else
				seq = tx_seq + 32'h8000_0000;
			pick = $urandom_range(0, 9);
			if (pick < 4)
				ivl = thr - 32'd2 + $urandom_range(0, 4);
			else if (pick < 7)
				ivl = $urandom_range(0, 1000);
			else if (pick < 9)
				ivl = $urandom();
			else
				ivl = ($urandom_range(0, 1) != 0) ? ALL_ONES : '0;
			send_packet(seq, tx_tick + ivl);
		end
		tx_steady = 1'b0;
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		test_first_packet();
		test_small_gaps();
		test_stall_threshold();
		test_random_traffic($urandom(), 300, 1'b0);
		test_random_traffic('0, 300, 1'b0);
		test_random_traffic(32'd100, 300, 1'b0);
		test_backpressure();
		test_gap_extremes();
		test_random_traffic(ALL_ONES, 300, 1'b1);
		test_random_traffic(STALL_THR_RST, 300, 1'b1);
		test_random_traffic($urandom(), 300, 1'b1);

		wait_idle();
		repeat (20) @(posedge clk);
		$display("covered %0d packets, %0d results checked, %0d gap events, %0d clusters closed",
			n_packets, n_checked, n_gap_events, n_closes);
		$display("%0d stalls flagged over %0d threshold writes, with full-queue backpressure",
			n_stalls, n_thr_writes);
		if (n_fail == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
